FILE: src/pscc_pkg.sv
// ============================================================================
// pscc_pkg
// Shared types, sizes and codes for the Pauli set Clifford conjugation unit.
// ============================================================================
package pscc_pkg;

    // Storage sizes
    localparam int MAX_ROWS  = 256;
    localparam int MAX_WORDS = 2;
    localparam int WORD_W    = 64;

    localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WIDX_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int ROW_BITS = MAX_WORDS * WORD_W;
    localparam int QBIT_W   = $clog2(ROW_BITS);
    localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
    localparam int WCNT_W   = $clog2(MAX_WORDS + 1);

    // Field widths
    localparam int ROWS_CFG_W  = 9;
    localparam int WORDS_CFG_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int ROW_IDX_W   = 8;
    localparam int QUBIT_W     = 7;
    localparam int PHASE_W     = 2;

    localparam int IN_TDATA_W  = 160;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 136;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WORDS = 1'b1;

    typedef enum logic [1:0] {
        ACT_WR_WORD  = 2'd0,
        ACT_WR_PHASE = 2'd1,
        ACT_GATE     = 2'd2,
        ACT_READ     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        GATE_H    = 2'd0,
        GATE_S    = 2'd1,
        GATE_SDAG = 2'd2,
        GATE_CX   = 2'd3
    } t_gate;

    typedef logic [MAX_WORDS-1:0][WORD_W-1:0] t_row;
    typedef logic [ROW_BITS-1:0]              t_flat;

    // One input word, unpacked
    typedef struct packed {
        t_action              action;
        logic [ROW_IDX_W-1:0] row_index;
        logic                 word_index;
        logic [WORD_W-1:0]    x_word_in;
        logic [WORD_W-1:0]    z_word_in;
        logic [PHASE_W-1:0]   phase_in;
        t_gate                gate_kind;
        logic [QUBIT_W-1:0]   qubit_a;
        logic [QUBIT_W-1:0]   qubit_b;
    } t_item;

    // Controller -> datapath
    typedef struct packed {
        logic              take;
        logic              do_write;
        logic              rd_item;
        logic              rd_sweep;
        logic [ROW_AW-1:0] sweep_row;
        logic              load_out;
        logic              out_read;
        logic              out_status;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_action           action;
        logic              ok;
        logic [RCNT_W-1:0] rows;
    } t_stat;

endpackage

FILE: src/pscc_dp.sv
// ============================================================================
// pscc_dp
// Datapath: config registers, item register, row stores, gate update logic,
// range checks and the result register.
// ============================================================================
module pscc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pscc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pscc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  pscc_pkg::t_item               i_item,
    input  pscc_pkg::t_cmd                i_cmd,
    output pscc_pkg::t_stat               o_stat,
    output logic [pscc_pkg::WORD_W-1:0]   o_x_word_out,
    output logic [pscc_pkg::WORD_W-1:0]   o_z_word_out,
    output logic [pscc_pkg::PHASE_W-1:0]  o_phase_out,
    output logic                          o_status
);
    import pscc_pkg::*;

    // Config and item registers
    logic [ROWS_CFG_W-1:0]  r_active_rows;
    logic [WORDS_CFG_W-1:0] r_active_words;
    t_item                  r_item;

    // Row stores (undefined until written)
    t_row               r_x_mem [MAX_ROWS];
    t_row               r_z_mem [MAX_ROWS];
    logic [PHASE_W-1:0] r_p_mem [MAX_ROWS];

    // Registered read data and write-back pipeline
    t_row               r_rx;
    t_row               r_rz;
    logic [PHASE_W-1:0] r_rp;
    logic               r_wb_pend;
    logic [ROW_AW-1:0]  r_wb_row;

    // Result register
    logic [WORD_W-1:0]  r_out_x;
    logic [WORD_W-1:0]  r_out_z;
    logic [PHASE_W-1:0] r_out_p;
    logic               r_out_st;

    logic [RCNT_W-1:0]  rows_use;
    logic [WCNT_W-1:0]  words_use;
    logic               row_ok;
    logic               word_ok;
    logic               qa_ok;
    logic               qb_ok;
    logic               item_ok;
    logic [ROW_AW-1:0]  item_row;
    logic [WIDX_W-1:0]  item_widx;
    logic [ROW_AW-1:0]  rd_addr;
    logic [QBIT_W-1:0]  qa_i;
    logic [QBIT_W-1:0]  qb_i;
    t_flat              xf;
    t_flat              zf;
    t_flat              gx;
    t_flat              gz;
    logic [PHASE_W-1:0] gp;
    logic               xa;
    logic               za;
    logic               xb;
    logic               zb;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_rows  <= ROWS_CFG_W'(256);
            r_active_words <= WORDS_CFG_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_ROWS:  r_active_rows  <= i_cfg_data;
                CFG_ACTIVE_WORDS: r_active_words <= i_cfg_data[WORDS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_item;
        end
    end

    // Range checks against the clamped limits
    always_comb begin
        rows_use  = (32'(r_active_rows) > MAX_ROWS) ? RCNT_W'(MAX_ROWS)
                                                    : RCNT_W'(r_active_rows);
        words_use = (32'(r_active_words) > MAX_WORDS) ? WCNT_W'(MAX_WORDS)
                                                      : WCNT_W'(r_active_words);
        row_ok  = 32'(r_item.row_index) < 32'(rows_use);
        word_ok = 32'(r_item.word_index) < 32'(words_use);
        qa_ok   = 32'(r_item.qubit_a) < (32'(words_use) << 6);
        qb_ok   = 32'(r_item.qubit_b) < (32'(words_use) << 6);
        case (r_item.action)
            ACT_WR_WORD:  item_ok = row_ok && word_ok;
            ACT_WR_PHASE: item_ok = row_ok;
            ACT_GATE:     item_ok = qa_ok && (r_item.gate_kind != GATE_CX || qb_ok);
            ACT_READ:     item_ok = row_ok && word_ok;
            default:      item_ok = 1'b0;
        endcase
    end

    assign o_stat.action = r_item.action;
    assign o_stat.ok     = item_ok;
    assign o_stat.rows   = rows_use;

    assign item_row  = ROW_AW'(r_item.row_index);
    assign item_widx = WIDX_W'(r_item.word_index);
    assign rd_addr   = i_cmd.rd_sweep ? i_cmd.sweep_row : item_row;

    // Gate update of one row
    always_comb begin
        xf   = r_rx;
        zf   = r_rz;
        qa_i = QBIT_W'(r_item.qubit_a);
        qb_i = QBIT_W'(r_item.qubit_b);
        xa   = xf[qa_i];
        za   = zf[qa_i];
        xb   = xf[qb_i];
        zb   = zf[qb_i];
        gx   = xf;
        gz   = zf;
        gp   = r_rp;
        case (r_item.gate_kind)
            GATE_H: begin
                gx[qa_i] = za;
                gz[qa_i] = xa;
                gp       = r_rp + {xa & za, 1'b0};
            end
            GATE_S: begin
                gz[qa_i] = za ^ xa;
                gp       = r_rp + {1'b0, xa};
            end
            GATE_SDAG: begin
                gz[qa_i] = za ^ xa;
                gp       = r_rp + {xa, xa};
            end
            GATE_CX: begin
                // old values on the right, so equal qubits clear both bits
                gx[qb_i] = xb ^ xa;
                gz[qa_i] = za ^ zb;
            end
            default: ;
        endcase
    end

    // Store write port: gate write-back, else item write
    always_ff @(posedge i_clk) begin
        if (r_wb_pend) begin
            r_x_mem[r_wb_row] <= gx;
            r_z_mem[r_wb_row] <= gz;
            r_p_mem[r_wb_row] <= gp;
        end else if (i_cmd.do_write) begin
            if (r_item.action == ACT_WR_PHASE) begin
                r_p_mem[item_row] <= r_item.phase_in;
            end else begin
                r_x_mem[item_row][item_widx] <= r_item.x_word_in;
                r_z_mem[item_row][item_widx] <= r_item.z_word_in;
            end
        end
    end

    // Store read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_item || i_cmd.rd_sweep) begin
            r_rx <= r_x_mem[rd_addr];
            r_rz <= r_z_mem[rd_addr];
            r_rp <= r_p_mem[rd_addr];
        end
    end

    // Write-back follows each sweep read in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_pend <= 1'b0;
        end else begin
            r_wb_pend <= i_cmd.rd_sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_row <= i_cmd.sweep_row;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.out_read) begin
                r_out_x <= r_rx[item_widx];
                r_out_z <= r_rz[item_widx];
                r_out_p <= r_rp;
            end else begin
                r_out_x <= '0;
                r_out_z <= '0;
                r_out_p <= '0;
            end
            r_out_st <= i_cmd.out_status;
        end
    end

    assign o_x_word_out = r_out_x;
    assign o_z_word_out = r_out_z;
    assign o_phase_out  = r_out_p;
    assign o_status     = r_out_st;

endmodule

FILE: src/pscc_ctrl.sv
// ============================================================================
// pscc_ctrl
// Controller: accepts words, sequences writes, reads and the row sweep of a
// gate, and owns the output valid flag.
// ============================================================================
module pscc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_valid,
    output logic            o_s_ready,
    output logic            o_m_valid,
    input  logic            i_m_tready,
    input  pscc_pkg::t_stat i_stat,
    output pscc_pkg::t_cmd  o_cmd
);
    import pscc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SWEEP,
        ST_DRAIN,
        ST_POST
    } t_state;

    t_state            r_state, n_state;
    logic [RCNT_W-1:0] r_row, n_row;
    logic              r_status, n_status;
    logic              r_out_read, n_out_read;
    logic              r_out_valid, n_out_valid;
    logic              out_free;
    logic              accept;

    assign out_free  = !r_out_valid || i_m_tready;
    assign o_s_ready = (r_state == ST_IDLE);
    assign accept    = i_s_valid && o_s_ready;
    assign o_m_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_status    = r_status;
        n_out_read  = r_out_read;
        n_out_valid = r_out_valid && !i_m_tready;

        o_cmd            = '0;
        o_cmd.take       = accept;
        o_cmd.sweep_row  = r_row[ROW_AW-1:0];
        o_cmd.out_read   = r_out_read;
        o_cmd.out_status = r_status;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_status   = !i_stat.ok;
                n_out_read = 1'b0;
                n_row      = '0;
                n_state    = ST_POST;
                if (i_stat.ok) begin
                    case (i_stat.action)
                        ACT_WR_WORD,
                        ACT_WR_PHASE: o_cmd.do_write = 1'b1;
                        ACT_READ: begin
                            o_cmd.rd_item = 1'b1;
                            n_out_read    = 1'b1;
                            n_state       = ST_RDWAIT;
                        end
                        ACT_GATE: begin
                            if (i_stat.rows != '0) begin
                                n_state = ST_SWEEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RDWAIT: begin
                n_state = ST_POST;
            end
            // One row read per cycle; the datapath writes it back in the following cycle
            ST_SWEEP: begin
                o_cmd.rd_sweep = 1'b1;
                if (32'(r_row) + 1 == 32'(i_stat.rows)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_row = r_row + RCNT_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_POST;
            end
            ST_POST: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_status    <= 1'b0;
            r_out_read  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_status    <= n_status;
            r_out_read  <= n_out_read;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    // Sweep counter never passes the last active row
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SWEEP |-> 32'(r_row) < 32'(i_stat.rows))
        else $error("sweep row out of range");

    // Result register is loaded only when it is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> out_free)
        else $error("result overwritten before taken");

    // An accepted word always moves to execution
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_EXEC)
        else $error("accepted word not executed");

    // Sweep read and item write never share a cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_sweep |-> !o_cmd.do_write && !o_cmd.rd_item)
        else $error("store port conflict");
`endif

endmodule

FILE: src/pauli_set_clifford_conjugation_unit.sv
// m_axis_tvalid rises once ST_POST loads the result: reached from ST_EXEC for writes,
// rejected words and gates with no active rows, ST_RDWAIT for reads, else ST_DRAIN.
// Words are handled one at a time: s_axis_tready is high only in the idle state. A gate
// sweeps the store at one row read-modify-write per cycle, without stalls.
// A new word is accepted the cycle after the previous result is loaded.
// Synchronous active-low reset: active_rows = 256, active_words = 2; stores not cleared.
// ============================================================================
// pauli_set_clifford_conjugation_unit
// Stores a set of Paulis as x/z masks with phases and conjugates every active
// row by H, S, Sdag or CX; also writes and reads back single words and phases.
// ============================================================================
module pauli_set_clifford_conjugation_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config
    input  logic                             i_cfg_we,
    input  logic [pscc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pscc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // row_index, word_index, x_word_in, z_word_in, phase_in, gate_kind,
    // qubit_a, qubit_b, zero pad
    input  logic [pscc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [pscc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // x_word_out, z_word_out, phase_out, status, zero pad
    output logic [pscc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import pscc_pkg::*;

    t_item              item;
    t_cmd               cmd;
    t_stat              stat;
    logic [WORD_W-1:0]  x_out;
    logic [WORD_W-1:0]  z_out;
    logic [PHASE_W-1:0] p_out;
    logic               st_out;

    // Unpack input word
    always_comb begin
        item.action     = t_action'(s_axis_tuser);
        item.row_index  = s_axis_tdata[7:0];
        item.word_index = s_axis_tdata[8];
        item.x_word_in  = s_axis_tdata[72:9];
        item.z_word_in  = s_axis_tdata[136:73];
        item.phase_in   = s_axis_tdata[138:137];
        item.gate_kind  = t_gate'(s_axis_tdata[140:139]);
        item.qubit_a    = s_axis_tdata[147:141];
        item.qubit_b    = s_axis_tdata[154:148];
    end

    pscc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pscc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item       (item),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_x_word_out (x_out),
        .o_z_word_out (z_out),
        .o_phase_out  (p_out),
        .o_status     (st_out)
    );

    // Pack result word
    assign m_axis_tdata = {5'b0, st_out, p_out, z_out, x_out};

endmodule
